>>> rtl/core/vep_pkg.sv
// shared constants, codes and types of the vt100 escape parser
package vep_pkg;

  // sizes
  localparam int unsigned MAX_ARGS_DEF = 8;
  localparam int unsigned ARG_W        = 16;
  localparam int unsigned CMD_W        = 5;
  localparam int unsigned VAL_W        = 17;
  localparam int unsigned ACT_W        = 2;

  localparam logic [ARG_W-1:0] ARG_LIMIT   = 16'hFFFF;
  localparam logic [7:0]       ROWS_RESET  = 8'd24;

  // received byte codes
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = "[";
  localparam logic [7:0] CH_QUEST   = "?";
  localparam logic [7:0] CH_SEMI    = ";";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_SEVEN   = "7";
  localparam logic [7:0] CH_EIGHT   = "8";
  localparam logic [7:0] CH_LPAREN  = "(";
  localparam logic [7:0] CH_RPAREN  = ")";
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_UC_A    = "A";
  localparam logic [7:0] CH_UC_B    = "B";
  localparam logic [7:0] CH_UC_C    = "C";
  localparam logic [7:0] CH_UC_D    = "D";
  localparam logic [7:0] CH_UC_E    = "E";
  localparam logic [7:0] CH_UC_H    = "H";
  localparam logic [7:0] CH_UC_J    = "J";
  localparam logic [7:0] CH_UC_K    = "K";
  localparam logic [7:0] CH_UC_L    = "L";
  localparam logic [7:0] CH_UC_M    = "M";
  localparam logic [7:0] CH_UC_P    = "P";
  localparam logic [7:0] CH_LC_F    = "f";
  localparam logic [7:0] CH_LC_H    = "h";
  localparam logic [7:0] CH_LC_L    = "l";
  localparam logic [7:0] CH_LC_M    = "m";
  localparam logic [7:0] CH_LC_R    = "r";

  // screen command codes
  localparam logic [CMD_W-1:0] CMD_PRINT      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_SCROLL_UP  = 5'd1;
  localparam logic [CMD_W-1:0] CMD_NEWLINE    = 5'd2;
  localparam logic [CMD_W-1:0] CMD_SCROLL_DN  = 5'd3;
  localparam logic [CMD_W-1:0] CMD_SAVE       = 5'd4;
  localparam logic [CMD_W-1:0] CMD_RESTORE    = 5'd5;
  localparam logic [CMD_W-1:0] CMD_UP         = 5'd6;
  localparam logic [CMD_W-1:0] CMD_DOWN       = 5'd7;
  localparam logic [CMD_W-1:0] CMD_RIGHT      = 5'd8;
  localparam logic [CMD_W-1:0] CMD_LEFT       = 5'd9;
  localparam logic [CMD_W-1:0] CMD_POSITION   = 5'd10;
  localparam logic [CMD_W-1:0] CMD_HOME       = 5'd11;
  localparam logic [CMD_W-1:0] CMD_ERASE_DISP = 5'd12;
  localparam logic [CMD_W-1:0] CMD_ERASE_LINE = 5'd13;
  localparam logic [CMD_W-1:0] CMD_ATTR       = 5'd14;
  localparam logic [CMD_W-1:0] CMD_REGION     = 5'd15;
  localparam logic [CMD_W-1:0] CMD_INS_LINES  = 5'd16;
  localparam logic [CMD_W-1:0] CMD_DEL_LINES  = 5'd17;
  localparam logic [CMD_W-1:0] CMD_DEL_CHARS  = 5'd18;
  localparam logic [CMD_W-1:0] CMD_KEYMODE    = 5'd19;

  // attribute actions
  localparam logic [ACT_W-1:0] ACT_KEEP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_OFF  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ON   = 2'd2;

  // sgr, erase and key mode argument values
  localparam logic [ARG_W-1:0] SGR_RESET     = 16'd0;
  localparam logic [ARG_W-1:0] SGR_UNDERLINE = 16'd4;
  localparam logic [ARG_W-1:0] SGR_REVERSE   = 16'd7;
  localparam logic [ARG_W-1:0] ERASE_MAX     = 16'd2;
  localparam logic [ARG_W-1:0] KEYMODE_ARG   = 16'd1;

  // escape parse phase
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_CSI    = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  // digit write into the argument store
  typedef struct packed {
    logic       wr_en;
    logic       fresh;
    logic [3:0] digit;
  } arg_wr_t;

endpackage

>>> rtl/core/vep_if.sv
// valid/ready channels for received bytes and screen commands

interface vep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface vep_cmd_if
  import vep_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [7:0]              char_code;
  logic signed [VAL_W-1:0] first_value;
  logic signed [VAL_W-1:0] second_value;
  logic [ACT_W-1:0]        underline_action;
  logic [ACT_W-1:0]        reverse_action;
  logic                    application_keys;

  modport source (output valid, output command, output char_code, output first_value,
                  output second_value, output underline_action, output reverse_action,
                  output application_keys, input ready);
  modport sink   (input valid, input command, input char_code, input first_value,
                  input second_value, input underline_action, input reverse_action,
                  input application_keys, output ready);
endinterface

>>> rtl/core/vt100_escape_parser_top.sv
// vt100 escape parser top level: byte intake, sequencer and command output
//
// Usage:
//   byte_ch carries one received terminal byte per transfer; cmd_ch carries
//   at most one screen command per byte. cfg_we/cfg_wdata write screen_rows,
//   which bounds the bottom of a scroll region; write it only while idle.
//   A byte is taken in the idle state and decoded in the next cycle; a
//   byte that yields a command has its result staged in registers and
//   waits in the staging state until the output register is free, while
//   a byte that yields none returns to idle from decode. An SGR ('m')
//   byte walks its stored arguments through the indexed argument read
//   port, one per cycle, before it moves to the staging state.
//   The output register lets the next byte be taken while a command still
//   waits on cmd_ch; if the receiver stalls, the following command waits in
//   the staging state and byte_ch.ready stays low until the slot frees.
//   Reset (rst, synchronous) returns to normal text, cursor key mode, no
//   arguments, screen_rows 24, and an empty output register.
//   application_keys in every command is the key mode after that byte.
module vt100_escape_parser_top
  import vep_pkg::*;
#(
  parameter int unsigned MAX_ARGS = MAX_ARGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  vep_byte_if.sink    byte_ch,
  vep_cmd_if.source   cmd_ch
);

  localparam int unsigned CW = $clog2(MAX_ARGS + 1);
  localparam int unsigned IW = $clog2(MAX_ARGS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SGR  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] walk, walk_next;
  logic          expect_new, expect_new_next;
  logic          key_mode, key_mode_next;
  logic [7:0]    screen_rows;
  logic [7:0]    byte_reg;

  // staged result
  logic [CMD_W-1:0]        res_cmd, res_cmd_next;
  logic [7:0]              res_char, res_char_next;
  logic signed [VAL_W-1:0] res_first, res_first_next;
  logic signed [VAL_W-1:0] res_second, res_second_next;
  logic [ACT_W-1:0]        res_ul, res_ul_next;
  logic [ACT_W-1:0]        res_rv, res_rv_next;

  // output register
  logic                    out_valid;
  logic [CMD_W-1:0]        out_cmd;
  logic [7:0]              out_char;
  logic signed [VAL_W-1:0] out_first;
  logic signed [VAL_W-1:0] out_second;
  logic [ACT_W-1:0]        out_ul;
  logic [ACT_W-1:0]        out_rv;
  logic                    out_keys;

  logic [IW-1:0]    arg_idx;
  arg_wr_t          arg_wr;
  logic [ARG_W-1:0] arg_rd;
  logic [ARG_W-1:0] arg0;
  logic [ARG_W-1:0] arg1;

  logic             cnt_zero;
  logic             cnt_two;
  logic             is_digit;
  logic             fresh_arg;
  logic             slot_free;
  logic [ARG_W-1:0] rows16;
  logic [ARG_W-1:0] count_or_one;
  logic [ARG_W-1:0] erase_mode;
  logic [ARG_W-1:0] region_top;
  logic [ARG_W-1:0] region_bot;

  vep_arg_file #(
    .MAX_ARGS (MAX_ARGS)
  ) u_args (
    .clk     (clk),
    .idx     (arg_idx),
    .wr      (arg_wr),
    .rd_data (arg_rd),
    .arg0    (arg0),
    .arg1    (arg1)
  );

  assign byte_ch.ready = (state == ST_IDLE);
  assign slot_free     = !out_valid || cmd_ch.ready;

  // decode helpers
  assign cnt_zero     = (count == '0);
  assign cnt_two      = (count == CW'(2));
  assign is_digit     = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
  assign fresh_arg    = expect_new || cnt_zero;
  assign rows16       = {8'd0, screen_rows};
  assign count_or_one = cnt_zero ? 16'd1 : arg0;
  assign erase_mode   = cnt_zero ? 16'd0 : arg0;
  assign region_top   = cnt_two ? arg0 : 16'd1;
  assign region_bot   = (cnt_two && (arg1 <= rows16)) ? arg1 : rows16;

  // sequencer and byte decode
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    count_next      = count;
    walk_next       = walk;
    expect_new_next = expect_new;
    key_mode_next   = key_mode;
    res_cmd_next    = res_cmd;
    res_char_next   = res_char;
    res_first_next  = res_first;
    res_second_next = res_second;
    res_ul_next     = res_ul;
    res_rv_next     = res_rv;
    arg_idx         = walk[IW-1:0];
    arg_wr          = '0;

    case (state)
      ST_IDLE: begin
        if (byte_ch.valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // default: no command, blank fields
        state_next      = ST_IDLE;
        res_char_next   = '0;
        res_first_next  = '0;
        res_second_next = '0;
        res_ul_next     = ACT_KEEP;
        res_rv_next     = ACT_KEEP;
        case (phase)
          PH_NORMAL: begin
            if (byte_reg == CH_ESC) begin
              count_next      = '0;
              expect_new_next = 1'b1;
              phase_next      = PH_ESCAPE;
            end else begin
              state_next    = ST_EMIT;
              res_cmd_next  = CMD_PRINT;
              res_char_next = byte_reg;
            end
          end

          PH_ESCAPE: begin
            phase_next = PH_NORMAL;
            case (byte_reg)
              CH_LBRACK: phase_next = PH_CSI;
              CH_UC_D: begin
                state_next   = ST_EMIT;
                res_cmd_next = CMD_SCROLL_UP;
              end
              CH_UC_E: begin
                state_next   = ST_EMIT;
                res_cmd_next = CMD_NEWLINE;
              end
              CH_UC_M: begin
                state_next   = ST_EMIT;
                res_cmd_next = CMD_SCROLL_DN;
              end
              CH_SEVEN: begin
                state_next   = ST_EMIT;
                res_cmd_next = CMD_SAVE;
              end
              CH_EIGHT: begin
                state_next   = ST_EMIT;
                res_cmd_next = CMD_RESTORE;
              end
              CH_LPAREN, CH_RPAREN, CH_HASH: phase_next = PH_SKIP;
              default: phase_next = PH_NORMAL;
            endcase
          end

          PH_CSI: begin
            phase_next = PH_NORMAL;
            case (byte_reg)
              CH_UC_A, CH_UC_B, CH_UC_C, CH_UC_D, CH_UC_L, CH_UC_M, CH_UC_P: begin
                state_next     = ST_EMIT;
                res_first_next = {1'b0, count_or_one};
                case (byte_reg)
                  CH_UC_A: res_cmd_next = CMD_UP;
                  CH_UC_B: res_cmd_next = CMD_DOWN;
                  CH_UC_C: res_cmd_next = CMD_RIGHT;
                  CH_UC_D: res_cmd_next = CMD_LEFT;
                  CH_UC_L: res_cmd_next = CMD_INS_LINES;
                  CH_UC_M: res_cmd_next = CMD_DEL_LINES;
                  default: res_cmd_next = CMD_DEL_CHARS;
                endcase
              end
              CH_UC_H, CH_LC_F: begin
                if (cnt_two) begin
                  state_next      = ST_EMIT;
                  res_cmd_next    = CMD_POSITION;
                  res_first_next  = {1'b0, arg0} - 17'sd1;
                  res_second_next = {1'b0, arg1} - 17'sd1;
                end else if (cnt_zero) begin
                  state_next   = ST_EMIT;
                  res_cmd_next = CMD_HOME;
                end
              end
              CH_UC_J, CH_UC_K: begin
                if (erase_mode <= ERASE_MAX) begin
                  state_next     = ST_EMIT;
                  res_cmd_next   = (byte_reg == CH_UC_J) ? CMD_ERASE_DISP : CMD_ERASE_LINE;
                  res_first_next = {1'b0, erase_mode};
                end
              end
              CH_LC_H, CH_LC_L: begin
                if ((count == CW'(1)) && (arg0 == KEYMODE_ARG)) begin
                  state_next    = ST_EMIT;
                  res_cmd_next  = CMD_KEYMODE;
                  key_mode_next = (byte_reg == CH_LC_H);
                end
              end
              CH_LC_M: begin
                // fold the arguments one per cycle
                state_next   = ST_SGR;
                walk_next    = '0;
                res_cmd_next = CMD_ATTR;
                res_ul_next  = cnt_zero ? ACT_OFF : ACT_KEEP;
                res_rv_next  = cnt_zero ? ACT_OFF : ACT_KEEP;
              end
              CH_LC_R: begin
                state_next      = ST_EMIT;
                res_cmd_next    = CMD_REGION;
                res_first_next  = {1'b0, region_top} - 17'sd1;
                res_second_next = {1'b0, region_bot} - 17'sd1;
              end
              CH_QUEST: phase_next = PH_CSI;
              CH_SEMI: begin
                phase_next      = PH_CSI;
                expect_new_next = 1'b1;
              end
              default: begin
                if (is_digit) begin
                  phase_next = PH_CSI;
                  if (fresh_arg) begin
                    // open a new argument unless the store is full
                    if (count < CW'(MAX_ARGS)) begin
                      arg_idx         = count[IW-1:0];
                      arg_wr.wr_en    = 1'b1;
                      arg_wr.fresh    = 1'b1;
                      arg_wr.digit    = byte_reg[3:0];
                      count_next      = count + CW'(1);
                      expect_new_next = 1'b0;
                    end
                  end else begin
                    arg_idx      = IW'(count - CW'(1));
                    arg_wr.wr_en = 1'b1;
                    arg_wr.digit = byte_reg[3:0];
                  end
                end
              end
            endcase
          end

          default: phase_next = PH_NORMAL;
        endcase
      end

      ST_SGR: begin
        if (walk == count) begin
          state_next = ST_EMIT;
        end else begin
          walk_next = walk + CW'(1);
          if (arg_rd == SGR_RESET) begin
            res_ul_next = ACT_OFF;
            res_rv_next = ACT_OFF;
          end else if (arg_rd == SGR_UNDERLINE) begin
            res_ul_next = ACT_ON;
          end else if (arg_rd == SGR_REVERSE) begin
            res_rv_next = ACT_ON;
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_NORMAL;
      count       <= '0;
      walk        <= '0;
      expect_new  <= 1'b1;
      key_mode    <= 1'b0;
      screen_rows <= ROWS_RESET;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      count      <= count_next;
      walk       <= walk_next;
      expect_new <= expect_new_next;
      key_mode   <= key_mode_next;
      if (cfg_we) begin
        screen_rows <= cfg_wdata;
      end
    end
  end

  // byte capture and staged result
  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      byte_reg <= byte_ch.byte_in;
    end
    res_cmd    <= res_cmd_next;
    res_char   <= res_char_next;
    res_first  <= res_first_next;
    res_second <= res_second_next;
    res_ul     <= res_ul_next;
    res_rv     <= res_rv_next;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && slot_free) begin
      out_valid <= 1'b1;
    end else if (cmd_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && slot_free) begin
      out_cmd    <= res_cmd;
      out_char   <= res_char;
      out_first  <= res_first;
      out_second <= res_second;
      out_ul     <= res_ul;
      out_rv     <= res_rv;
      out_keys   <= key_mode;
    end
  end

  assign cmd_ch.valid            = out_valid;
  assign cmd_ch.command          = out_cmd;
  assign cmd_ch.char_code        = out_char;
  assign cmd_ch.first_value      = out_first;
  assign cmd_ch.second_value     = out_second;
  assign cmd_ch.underline_action = out_ul;
  assign cmd_ch.reverse_action   = out_rv;
  assign cmd_ch.application_keys = out_keys;

endmodule

>>> rtl/core/vep_arg_file.sv
// csi argument store with the shared decimal accumulate unit
module vep_arg_file
  import vep_pkg::*;
#(
  parameter int unsigned MAX_ARGS = MAX_ARGS_DEF,
  localparam int unsigned IW = $clog2(MAX_ARGS)
) (
  input  logic             clk,
  input  logic [IW-1:0]    idx,
  input  arg_wr_t          wr,
  output logic [ARG_W-1:0] rd_data,
  output logic [ARG_W-1:0] arg0,
  output logic [ARG_W-1:0] arg1
);

  logic [ARG_W-1:0] args [MAX_ARGS];
  logic [ARG_W-1:0] base;
  logic [ARG_W+3:0] acc;

  // read port shared by the digit unit and the attribute walk
  assign rd_data = args[idx];
  assign arg0    = args[0];
  assign arg1    = args[1];

  // value * 10 + digit, saturating
  assign base = wr.fresh ? '0 : rd_data;
  assign acc  = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {{ARG_W{1'b0}}, wr.digit};

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      args[idx] <= (acc > {4'd0, ARG_LIMIT}) ? ARG_LIMIT : acc[ARG_W-1:0];
    end
  end

endmodule

>>> test/vt100_escape_parser_checker.sv
`timescale 1ns / 1ps
// command predictor and checker for the vt100 escape parser channels
module vt100_escape_parser_checker
  import vep_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_wdata,
  vep_byte_if byte_mon,
  vep_cmd_if  cmd_mon,
  output int  fail_count,
  output int  pending,
  output int  checked,
  output int  kinds_seen
);

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [7:0]       char_code;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic [ACT_W-1:0] underline_action;
    logic [ACT_W-1:0] reverse_action;
    logic             application_keys;
  } screen_cmd_t;

  screen_cmd_t expected_cmds[$];

  // predicted parser state
  phase_t           phase;
  int unsigned      arg_count;
  bit               fresh_arg;
  logic [ARG_W-1:0] arg_vals [MAX_ARGS_DEF];
  logic [7:0]       rows;
  bit               app_keys;

  int        errors = 0;
  int        results = 0;
  bit [31:0] kinds = '0;

  assign fail_count = errors;
  assign pending    = expected_cmds.size();
  assign checked    = results;
  assign kinds_seen = $countones(kinds);

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [7:0] ch,
                          input int first, input int second,
                          input logic [ACT_W-1:0] ul, input logic [ACT_W-1:0] rv);
    screen_cmd_t r;
    r.command          = cmd;
    r.char_code        = ch;
    r.first_value      = first[VAL_W-1:0];
    r.second_value     = second[VAL_W-1:0];
    r.underline_action = ul;
    r.reverse_action   = rv;
    r.application_keys = app_keys;
    expected_cmds.push_back(r);
  endtask

  // accumulate one decimal digit into the current argument
  task automatic add_digit(input logic [7:0] c);
    int acc;
    phase = PH_CSI;
    if (fresh_arg || arg_count == 0) begin
      if (arg_count >= MAX_ARGS_DEF) return;
      arg_vals[arg_count] = '0;
      arg_count++;
      fresh_arg = 1'b0;
    end
    acc = int'(arg_vals[arg_count-1]) * 10 + int'(c - CH_ZERO);
    arg_vals[arg_count-1] = (acc > int'(ARG_LIMIT)) ? ARG_LIMIT : acc[ARG_W-1:0];
  endtask

  // byte inside a csi sequence
  task automatic csi_byte(input logic [7:0] c);
    int               cnt, mode, top, bot;
    logic [ACT_W-1:0] ul, rv;
    phase = PH_NORMAL;
    cnt = (arg_count != 0) ? int'(arg_vals[0]) : 1;
    case (c)
      CH_UC_A: push_cmd(CMD_UP, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_B: push_cmd(CMD_DOWN, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_C: push_cmd(CMD_RIGHT, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_D: push_cmd(CMD_LEFT, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_L: push_cmd(CMD_INS_LINES, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_M: push_cmd(CMD_DEL_LINES, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_P: push_cmd(CMD_DEL_CHARS, 8'h00, cnt, 0, ACT_KEEP, ACT_KEEP);
      CH_UC_H, CH_LC_F: begin
        if (arg_count == 2)
          push_cmd(CMD_POSITION, 8'h00, int'(arg_vals[0]) - 1, int'(arg_vals[1]) - 1,
                   ACT_KEEP, ACT_KEEP);
        else if (arg_count == 0)
          push_cmd(CMD_HOME, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
      end
      CH_UC_J, CH_UC_K: begin
        mode = (arg_count != 0) ? int'(arg_vals[0]) : 0;
        if (mode <= int'(ERASE_MAX))
          push_cmd((c == CH_UC_J) ? CMD_ERASE_DISP : CMD_ERASE_LINE, 8'h00, mode, 0,
                   ACT_KEEP, ACT_KEEP);
      end
      CH_LC_H, CH_LC_L: begin
        if (arg_count == 1 && arg_vals[0] == KEYMODE_ARG) begin
          app_keys = (c == CH_LC_H);
          push_cmd(CMD_KEYMODE, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
        end
      end
      CH_LC_M: begin
        // no args means all off, otherwise fold args in order
        ul = (arg_count == 0) ? ACT_OFF : ACT_KEEP;
        rv = ul;
        for (int i = 0; i < arg_count; i++) begin
          if (arg_vals[i] == SGR_RESET) begin
            ul = ACT_OFF;
            rv = ACT_OFF;
          end else if (arg_vals[i] == SGR_UNDERLINE) begin
            ul = ACT_ON;
          end else if (arg_vals[i] == SGR_REVERSE) begin
            rv = ACT_ON;
          end
        end
        push_cmd(CMD_ATTR, 8'h00, 0, 0, ul, rv);
      end
      CH_LC_R: begin
        if (arg_count != 2) begin
          top = 1;
          bot = int'(rows);
        end else begin
          top = int'(arg_vals[0]);
          bot = int'(arg_vals[1]);
          if (bot > int'(rows)) bot = int'(rows);
        end
        push_cmd(CMD_REGION, 8'h00, top - 1, bot - 1, ACT_KEEP, ACT_KEEP);
      end
      CH_QUEST: phase = PH_CSI;
      CH_SEMI: begin
        fresh_arg = 1'b1;
        phase = PH_CSI;
      end
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) add_digit(c);
      end
    endcase
  endtask

  // one received byte through the parse phases
  task automatic decode_byte(input logic [7:0] c);
    case (phase)
      PH_NORMAL: begin
        if (c == CH_ESC) begin
          arg_count = 0;
          fresh_arg = 1'b1;
          arg_vals[0] = '0;
          phase = PH_ESCAPE;
        end else begin
          push_cmd(CMD_PRINT, c, 0, 0, ACT_KEEP, ACT_KEEP);
        end
      end
      PH_ESCAPE: begin
        phase = PH_NORMAL;
        case (c)
          CH_LBRACK: phase = PH_CSI;
          CH_UC_D:   push_cmd(CMD_SCROLL_UP, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
          CH_UC_E:   push_cmd(CMD_NEWLINE, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
          CH_UC_M:   push_cmd(CMD_SCROLL_DN, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
          CH_SEVEN:  push_cmd(CMD_SAVE, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
          CH_EIGHT:  push_cmd(CMD_RESTORE, 8'h00, 0, 0, ACT_KEEP, ACT_KEEP);
          CH_LPAREN, CH_RPAREN, CH_HASH: phase = PH_SKIP;
          default: ;
        endcase
      end
      PH_CSI: csi_byte(c);
      default: phase = PH_NORMAL;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    screen_cmd_t want;
    if (rst) begin
      phase = PH_NORMAL;
      arg_count = 0;
      fresh_arg = 1'b1;
      for (int i = 0; i < MAX_ARGS_DEF; i++) arg_vals[i] = '0;
      rows = ROWS_RESET;
      app_keys = 1'b0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) rows = cfg_wdata;
      // compare a command transfer with the oldest expectation
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("command %0d transferred with none expected", cmd_mon.command);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("command", want.command, cmd_mon.command);
          check_field("char_code", want.char_code, cmd_mon.char_code);
          check_field("first_value", int'($signed(want.first_value)),
                      int'(cmd_mon.first_value));
          check_field("second_value", int'($signed(want.second_value)),
                      int'(cmd_mon.second_value));
          check_field("underline_action", want.underline_action, cmd_mon.underline_action);
          check_field("reverse_action", want.reverse_action, cmd_mon.reverse_action);
          check_field("application_keys", want.application_keys, cmd_mon.application_keys);
          kinds[cmd_mon.command] = 1'b1;
          results++;
        end
      end
      // predict from a byte transfer
      if (byte_mon.valid && byte_mon.ready) decode_byte(byte_mon.byte_in);
    end
  end

endmodule

>>> test/vt100_escape_parser_top_tb.sv
`timescale 1ns / 1ps
// byte stimulus, receiver stalls and verdict for the vt100 escape parser top
module vt100_escape_parser_top_tb
  import vep_pkg::*;
;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  vep_byte_if byte_ch();
  vep_cmd_if  cmd_ch();

  int send_gap_pct = 28;
  int recv_gap_pct = 47;
  bit hold_request = 1'b0;
  int bytes_sent = 0;
  int rows_settings = 1;
  int fail_count, pending, checked, kinds_seen;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vt100_escape_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .byte_ch  (byte_ch),
    .cmd_ch   (cmd_ch)
  );

  vt100_escape_parser_checker command_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_mon  (byte_ch),
    .cmd_mon   (cmd_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked),
    .kinds_seen(kinds_seen)
  );

  // offer one byte, with random idle cycles first, until it transfers
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_esc(input string s);
    send_byte(CH_ESC);
    send_text(s);
  endtask

  task automatic send_csi(input string s);
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    send_text(s);
  endtask

  // stop offering and wait until every command is out and the block is quiet
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_rows(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_settings++;
  endtask

  // argument values: sgr and erase codes, small counts, rows, saturating
  function automatic int arg_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 7);
    if (r < 65) return $urandom_range(0, 40);
    if (r < 90) return $urandom_range(0, 300);
    return $urandom_range(60000, 99999);
  endfunction

  // one random sequence: mostly well formed escapes, some noise
  task automatic random_sequence();
    string      esc_finals;
    string      csi_finals;
    string      body;
    int         pick, nargs;
    logic [7:0] fin;
    esc_finals = "DEM78()#z";
    csi_finals = "ABCDHfJKhlmrLMP";
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 22) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(32, 126)));
    end else if (pick < 34) begin
      send_byte(CH_ESC);
      if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(esc_finals[$urandom_range(0, esc_finals.len() - 1)]);
    end else begin
      body = ($urandom_range(0, 7) == 0) ? "?" : "";
      if (pick < 40) begin
        // key mode shaped
        body = {body, "1"};
        fin = $urandom_range(0, 1) ? CH_LC_H : CH_LC_L;
      end else begin
        nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 11) : $urandom_range(0, 2);
        for (int i = 0; i < nargs; i++) begin
          if (i > 0) body = {body, ";"};
          if ($urandom_range(0, 11) != 0) body = {body, $sformatf("%0d", arg_value())};
        end
        if ($urandom_range(0, 6) == 0) fin = 8'($urandom_range(0, 255));
        else fin = csi_finals[$urandom_range(0, csi_finals.len() - 1)];
      end
      send_csi(body);
      send_byte(fin);
    end
  endtask

  task automatic random_burst(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) random_sequence();
  endtask

  // receiver: random stalls, and one long hold-off on request
  initial begin
    cmd_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        cmd_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      cmd_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // stimulus and verdict
  initial begin
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every command, special cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_esc("D");
    send_esc("E");
    send_esc("M");
    send_esc("7");
    send_esc("8");
    send_esc("(A");
    send_esc(")B");
    send_esc("#8");
    send_esc("z");
    send_csi("?1h");
    send_csi("A");
    send_csi("0B");
    send_csi("12C");
    send_csi("123456D");
    send_csi("3;7H");
    send_csi("H");
    send_csi("5H");
    send_csi("1;2;3f");
    send_csi("0;0f");
    send_csi("J");
    send_csi("2J");
    send_csi("3K");
    send_csi("1K");
    send_csi("?1l");
    send_csi("2h");
    send_csi("1;1h");
    send_csi("m");
    send_csi("7;0;4;9m");
    send_csi("0;0;0;0;0;0;0;0;4;7m");
    send_csi("5;30r");
    send_csi("0;0r");
    send_csi("3r");
    send_csi(";5H");
    send_csi("L");
    send_csi("4M");
    send_csi("0P");
    send_csi("1x");

    // long receiver hold-off while bytes keep coming
    hold_request = 1'b1;
    repeat (40) send_byte(8'($urandom_range(32, 126)));

    set_rows(8'd255);
    random_burst(240);

    // tiny screens
    set_rows(8'd0);
    send_csi("r");
    send_csi("2;9r");
    set_rows(8'd1);
    send_csi("r");
    send_csi("1;5r");

    send_gap_pct = 47;
    recv_gap_pct = 28;
    random_burst(240);

    set_rows(8'($urandom_range(2, 254)));
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_burst(230);

    drain();
    $display("sent %0d bytes over %0d screen-row settings; checked %0d commands, %0d of 20 kinds",
             bytes_sent, rows_settings, checked, kinds_seen);
    if (fail_count == 0) begin
      $display("vt100_escape_parser_top verification clean");
    end else begin
      $display("vt100_escape_parser_top verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("vt100_escape_parser_top verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/vep_pkg.sv
rtl/core/vep_if.sv
rtl/core/vep_arg_file.sv
rtl/core/vt100_escape_parser_top.sv
test/vt100_escape_parser_checker.sv
test/vt100_escape_parser_top_tb.sv
